// ===== rtl/core/sumo_robot_combat_controller_macros.svh =====
// assertion macros for the combat controller
`ifndef SUMO_ROBOT_COMBAT_CONTROLLER_MACROS_SVH
`define SUMO_ROBOT_COMBAT_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define SRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SRC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/src_pkg.sv =====
package src_pkg;
  localparam logic [2:0] MODE_WAIT   = 3'd0;
  localparam logic [2:0] MODE_SEARCH = 3'd1;
  localparam logic [2:0] MODE_ATTACK = 3'd2;
  localparam logic [2:0] MODE_BACK   = 3'd3;
  localparam logic [2:0] MODE_TURN   = 3'd4;

  localparam logic [2:0] REG_ON    = 3'd0;
  localparam logic [2:0] REG_OFF   = 3'd1;
  localparam logic [2:0] REG_HOLD  = 3'd2;
  localparam logic [2:0] REG_START = 3'd3;
  localparam logic [2:0] REG_BACK  = 3'd4;
  localparam logic [2:0] REG_TURN  = 3'd5;
  localparam logic [2:0] REG_SPIN  = 3'd6;
  localparam logic [2:0] REG_PROBE = 3'd7;

  localparam logic signed [8:0] SPEED_ATTACK = 9'sd255;
  localparam logic signed [8:0] SPEED_BACK   = 9'sd230;
  localparam logic signed [8:0] SPEED_TURN   = 9'sd210;
  localparam logic signed [8:0] SPEED_SEARCH = 9'sd175;
  localparam logic WHITE_LEVEL = 1'b0;

  // edge side codes
  localparam logic [1:0] SIDE_BOTH  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  typedef struct packed {
    logic [11:0] on_level;
    logic [11:0] off_level;
    logic [15:0] hold_ms;
    logic [15:0] start_ms;
    logic [15:0] back_ms;
    logic [15:0] turn_ms;
    logic [15:0] spin_ms;
    logic [15:0] probe_ms;
  } cfg_t;

  // classified tick passed from front to back
  typedef struct packed {
    logic        enemy;
    logic [11:0] median;
    logic        left_on;
    logic        right_on;
    logic [31:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic signed [8:0] left_speed;
    logic signed [8:0] right_speed;
    logic              coast;
    logic [2:0]        mode_code;
    logic              enemy_seen;
    logic [11:0]       median_sample;
    logic              left_on_line;
    logic              right_on_line;
  } result_t;
endpackage

// ===== rtl/core/sumo_robot_combat_controller.sv =====
// Combat controller, one control tick per request. The front debounces the line
// sensors, writes the distance sample into a ring and finds its median by testing
// one ring entry a cycle, then updates the enemy flag. The back runs the mode
// machine after a bit-serial 32-bit modulo for the search phase, then runs the
// mode step. The back takes no new tick until the output queue has taken its
// result. Front and back overlap through a two-entry queue, and results wait in
// a two-entry output queue.
`include "sumo_robot_combat_controller_macros.svh"
module sumo_robot_combat_controller import src_pkg::*; #(
  parameter int MEDIAN_TAPS   = 5,
  parameter int CONFIRM_COUNT = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [11:0]       in_distance_sample,
  input  logic              in_left_line_level,
  input  logic              in_right_line_level,
  input  logic [31:0]       in_now_ms,
  output logic              empty,
  input  logic              pop,
  output logic signed [8:0] out_left_speed,
  output logic signed [8:0] out_right_speed,
  output logic              out_coast,
  output logic [2:0]        out_mode_code,
  output logic              out_enemy_seen,
  output logic [11:0]       out_median_sample,
  output logic              out_left_on_line,
  output logic              out_right_on_line,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  cfg_t    cfg_r;
  logic    in_ready, f_valid, f_ready, q_valid, q_ready, r_valid, r_ready;
  tick_t   f_tick, q_tick;
  result_t r_res, o_res;
  logic    o_valid;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{12'd1250, 12'd1000, 16'd350, 16'd5000, 16'd220, 16'd260,
                 16'd480, 16'd300};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ON:    cfg_r.on_level  <= cfg_data[11:0];
        REG_OFF:   cfg_r.off_level <= cfg_data[11:0];
        REG_HOLD:  cfg_r.hold_ms   <= cfg_data;
        REG_START: cfg_r.start_ms  <= cfg_data;
        REG_BACK:  cfg_r.back_ms   <= cfg_data;
        REG_TURN:  cfg_r.turn_ms   <= cfg_data;
        REG_SPIN:  cfg_r.spin_ms   <= cfg_data;
        REG_PROBE: cfg_r.probe_ms  <= cfg_data;
        default:   cfg_r <= cfg_r;
      endcase
    end
  end

  assign full = !in_ready;

  src_front #(.MEDIAN_TAPS(MEDIAN_TAPS), .CONFIRM_COUNT(CONFIRM_COUNT)) u_front (
    .clk, .rst_n, .cfg(cfg_r), .in_valid(push), .in_ready,
    .distance_sample(in_distance_sample), .left_line_level(in_left_line_level),
    .right_line_level(in_right_line_level), .now_ms(in_now_ms),
    .tick_valid(f_valid), .tick_ready(f_ready), .tick(f_tick)
  );

  src_fifo #(.W($bits(tick_t))) u_tq (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_tick),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_tick)
  );

  src_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .tick_valid(q_valid), .tick_ready(q_ready),
    .tick(q_tick), .res_valid(r_valid), .res_ready(r_ready), .res(r_res)
  );

  src_fifo #(.W($bits(result_t))) u_rq (
    .clk, .rst_n, .wr_valid(r_valid), .wr_ready(r_ready), .wr_data(r_res),
    .rd_valid(o_valid), .rd_ready(pop), .rd_data(o_res)
  );

  assign empty             = !o_valid;
  assign out_left_speed    = o_res.left_speed;
  assign out_right_speed   = o_res.right_speed;
  assign out_coast         = o_res.coast;
  assign out_mode_code     = o_res.mode_code;
  assign out_enemy_seen    = o_res.enemy_seen;
  assign out_median_sample = o_res.median_sample;
  assign out_left_on_line  = o_res.left_on_line;
  assign out_right_on_line = o_res.right_on_line;

  `SRC_ASSERT_IMPL(a_mode_range, clk, rst_n, !empty, out_mode_code <= MODE_TURN)
  `SRC_ASSERT_IMPL(a_coast_stop, clk, rst_n, !empty && out_coast,
                   out_left_speed == 9'sd0 && out_right_speed == 9'sd0)
  `SRC_ASSERT_NEXT(a_push_busy, clk, rst_n, push && !full, full)
endmodule

// two-entry queue, used between stages and for results
module src_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         wr_fire, rd_fire;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_fire) begin
        mem_r[wp_r] <= wr_data;
        wp_r        <= ~wp_r;
      end
      if (rd_fire) rp_r <= ~rp_r;
      unique case ({wr_fire, rd_fire})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule

// ===== rtl/core/src_front.sv =====
module src_front import src_pkg::*; #(
  parameter int MEDIAN_TAPS   = 5,
  parameter int CONFIRM_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] distance_sample,
  input  logic        left_line_level,
  input  logic        right_line_level,
  input  logic [31:0] now_ms,
  output logic        tick_valid,
  input  logic        tick_ready,
  output tick_t       tick
);
  localparam int PW = $clog2(MEDIAN_TAPS);
  localparam int CW = $clog2(MEDIAN_TAPS + 1);
  localparam logic [PW-1:0] LAST_POS = PW'(MEDIAN_TAPS - 1);
  localparam logic [CW-1:0] MID_RANK = CW'(MEDIAN_TAPS / 2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RANK = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [11:0] ring_r [MEDIAN_TAPS];
  logic [PW-1:0] pos_r;
  logic [PW-1:0] idx_r;
  logic        lconf_r, rconf_r;
  logic [1:0]  lcnt_r, rcnt_r;
  logic        enemy_r;
  logic [31:0] elast_r;
  logic [31:0] now_r;
  tick_t       tick_r;

  logic [CW-1:0] less_cnt, le_cnt;
  logic [11:0]   cand;

  assign in_ready   = (state_r == ST_IDLE);
  assign tick_valid = (state_r == ST_SEND);
  assign tick       = tick_r;
  assign state_nxt  = state_r;

  // rank of candidate: median if less < mid+1 and less-or-equal > mid
  always_comb begin
    less_cnt = '0;
    le_cnt   = '0;
    cand     = ring_r[idx_r];
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      less_cnt = less_cnt + CW'(ring_r[i] < cand);
      le_cnt   = le_cnt + CW'(ring_r[i] <= cand);
    end
  end

  function automatic void deb(input logic raw, inout logic conf, inout logic [1:0] cnt);
    if (raw == conf) begin
      cnt = 2'd0;
    end else begin
      cnt = cnt + 2'd1;
      if (32'(cnt) >= CONFIRM_COUNT) begin
        conf = raw;
        cnt  = 2'd0;
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    logic lc, rc;
    logic [1:0] ln, rn;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < MEDIAN_TAPS; i++) ring_r[i] <= '0;
      pos_r   <= '0;
      idx_r   <= '0;
      lconf_r <= 1'b0;
      rconf_r <= 1'b0;
      lcnt_r  <= '0;
      rcnt_r  <= '0;
      enemy_r <= 1'b0;
      elast_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            lc = lconf_r; ln = lcnt_r; rc = rconf_r; rn = rcnt_r;
            deb(left_line_level == WHITE_LEVEL, lc, ln);
            deb(right_line_level == WHITE_LEVEL, rc, rn);
            lconf_r <= lc; lcnt_r <= ln; rconf_r <= rc; rcnt_r <= rn;
            ring_r[pos_r] <= distance_sample;
            pos_r   <= (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
            now_r   <= now_ms;
            idx_r   <= '0;
            state_r <= ST_RANK;
          end
        end
        // one candidate a cycle until the median is found
        ST_RANK: begin
          if (less_cnt <= MID_RANK && le_cnt > MID_RANK) begin
            state_r <= ST_SEND;
            tick_r.median   <= cand;
            tick_r.left_on  <= lconf_r;
            tick_r.right_on <= rconf_r;
            tick_r.now_ms   <= now_r;
            if (!enemy_r) begin
              if (cand >= cfg.on_level) begin
                enemy_r <= 1'b1; elast_r <= now_r; tick_r.enemy <= 1'b1;
              end else tick_r.enemy <= 1'b0;
            end else if (cand >= cfg.off_level) begin
              elast_r <= now_r; tick_r.enemy <= 1'b1;
            end else if ((now_r - elast_r) > 32'(cfg.hold_ms)) begin
              enemy_r <= 1'b0; tick_r.enemy <= 1'b0;
            end else tick_r.enemy <= 1'b1;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_SEND: begin
          if (tick_ready) state_r <= ST_IDLE;
        end
        default: state_r <= state_nxt;
      endcase
    end
  end
endmodule

// ===== rtl/core/src_back.sv =====
module src_back import src_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    tick_valid,
  output logic    tick_ready,
  input  tick_t   tick,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  state_r;
  logic [2:0]  mode_r;
  logic [31:0] entry_r;
  logic [1:0]  side_r;
  logic        spin_r; // 0 means +1
  logic signed [8:0] hl_r, hr_r;
  logic        hc_r;
  tick_t       t_r;
  logic [2:0]  mode_o_r;
  logic        enemy_o_r;
  logic [11:0] med_o_r;
  logic        lon_o_r, ron_o_r;
  // restoring modulo of elapsed by cycle length
  logic [31:0] rem_r, quo_r;
  logic [16:0] cyc_r;
  logic [5:0]  bit_r;
  logic [32:0] trial;

  assign tick_ready = (state_r == ST_IDLE);
  assign res_valid  = (state_r == ST_OUT);
  assign trial      = {rem_r, quo_r[31]} - {16'd0, cyc_r};

  always_ff @(posedge clk) begin
    logic [2:0]  m;
    logic [31:0] en, el;
    logic [16:0] dur;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_WAIT;
      entry_r <= '0;
      side_r  <= SIDE_BOTH;
      spin_r  <= 1'b0;
      hl_r    <= '0;
      hr_r    <= '0;
      hc_r    <= 1'b1;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (tick_valid) begin
            t_r <= tick;
            m  = mode_r;
            en = entry_r;
            // line overrides search and attack
            if ((m == MODE_SEARCH || m == MODE_ATTACK) && (tick.left_on || tick.right_on)) begin
              side_r <= (tick.left_on && tick.right_on) ? SIDE_BOTH
                      : (tick.left_on ? SIDE_LEFT : SIDE_RIGHT);
              m  = MODE_BACK;
              en = tick.now_ms;
            end
            el = tick.now_ms - en;
            mode_r  <= m;
            entry_r <= en;
            rem_r   <= '0;
            quo_r   <= el;
            cyc_r   <= 17'(cfg.spin_ms) + 17'(cfg.probe_ms);
            bit_r   <= '0;
            state_r <= ST_MOD;
          end
        end
        // one quotient bit a cycle, then run the mode step
        ST_MOD: begin
          if (bit_r != 6'd32) begin
            if (!trial[32]) rem_r <= trial[31:0];
            else rem_r <= {rem_r[30:0], quo_r[31]};
            quo_r <= {quo_r[30:0], 1'b0};
            bit_r <= bit_r + 6'd1;
          end else begin
            m  = mode_r;
            el = t_r.now_ms - entry_r;
            unique case (m)
              MODE_WAIT: begin
                hl_r <= '0; hr_r <= '0; hc_r <= 1'b1;
                if (el >= 32'(cfg.start_ms)) begin m = MODE_SEARCH; entry_r <= t_r.now_ms; end
              end
              MODE_SEARCH: begin
                if (t_r.enemy) begin
                  m = MODE_ATTACK; entry_r <= t_r.now_ms;
                end else if (cyc_r != '0 && rem_r < 32'(cfg.spin_ms)) begin
                  hl_r <= spin_r ? -SPEED_SEARCH : SPEED_SEARCH;
                  hr_r <= spin_r ? SPEED_SEARCH : -SPEED_SEARCH;
                  hc_r <= 1'b0;
                end else begin
                  hl_r <= SPEED_SEARCH; hr_r <= SPEED_SEARCH; hc_r <= 1'b0;
                end
              end
              MODE_ATTACK: begin
                if (!t_r.enemy) begin
                  m = MODE_SEARCH; entry_r <= t_r.now_ms;
                end else begin
                  hl_r <= SPEED_ATTACK; hr_r <= SPEED_ATTACK; hc_r <= 1'b0;
                end
              end
              MODE_BACK: begin
                hl_r <= -SPEED_BACK; hr_r <= -SPEED_BACK; hc_r <= 1'b0;
                if (el >= 32'(cfg.back_ms)) begin m = MODE_TURN; entry_r <= t_r.now_ms; end
              end
              default: begin
                hc_r <= 1'b0;
                if (side_r == SIDE_RIGHT) begin
                  hl_r <= -SPEED_TURN; hr_r <= SPEED_TURN;
                end else begin
                  hl_r <= SPEED_TURN; hr_r <= -SPEED_TURN;
                end
                dur = (side_r == SIDE_BOTH) ? {cfg.turn_ms, 1'b0} : 17'(cfg.turn_ms);
                if (el >= 32'(dur)) begin
                  spin_r <= ~spin_r; m = MODE_SEARCH; entry_r <= t_r.now_ms;
                end
              end
            endcase
            mode_r    <= m;
            mode_o_r  <= m;
            enemy_o_r <= t_r.enemy;
            med_o_r   <= t_r.median;
            lon_o_r   <= t_r.left_on;
            ron_o_r   <= t_r.right_on;
            state_r   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (res_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // drive fields follow held registers
  always_comb begin
    res.left_speed    = hl_r;
    res.right_speed   = hr_r;
    res.coast         = hc_r;
    res.mode_code     = mode_o_r;
    res.enemy_seen    = enemy_o_r;
    res.median_sample = med_o_r;
    res.left_on_line  = lon_o_r;
    res.right_on_line = ron_o_r;
  end
endmodule

// ===== test/tb_sumo_robot_combat_controller.sv =====
`timescale 1ns / 100ps
module tb_sumo_robot_combat_controller;
  import src_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 100;

  logic              clk;
  logic              rst_n;
  logic              push;
  logic              full;
  logic [11:0]       in_distance_sample;
  logic              in_left_line_level;
  logic              in_right_line_level;
  logic [31:0]       in_now_ms;
  logic              empty;
  logic              pop;
  logic signed [8:0] out_left_speed;
  logic signed [8:0] out_right_speed;
  logic              out_coast;
  logic [2:0]        out_mode_code;
  logic              out_enemy_seen;
  logic [11:0]       out_median_sample;
  logic              out_left_on_line;
  logic              out_right_on_line;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [15:0]       cfg_data;

  sumo_robot_combat_controller u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_distance_sample  (in_distance_sample),
    .in_left_line_level  (in_left_line_level),
    .in_right_line_level (in_right_line_level),
    .in_now_ms           (in_now_ms),
    .empty               (empty),
    .pop                 (pop),
    .out_left_speed      (out_left_speed),
    .out_right_speed     (out_right_speed),
    .out_coast           (out_coast),
    .out_mode_code       (out_mode_code),
    .out_enemy_seen      (out_enemy_seen),
    .out_median_sample   (out_median_sample),
    .out_left_on_line    (out_left_on_line),
    .out_right_on_line   (out_right_on_line),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // controller model state
  logic [11:0]       ring [5];
  int                ring_pos;
  logic              enemy_flag;
  logic [31:0]       enemy_time;
  logic              left_conf, right_conf;
  logic [1:0]        left_cnt, right_cnt;
  logic [2:0]        mode;
  logic [31:0]       mode_time;
  logic [1:0]        edge_side;
  logic              spin_ccw;
  logic signed [8:0] drive_left, drive_right;
  logic              drive_coast;
  logic [31:0]       reg_val [8];

  result_t           expected_ticks [$];
  int                errors;
  int                ticks_sent;
  int                ticks_done;
  int                cfg_writes;
  int                idle_cycles;
  bit                stall_mode;
  logic [31:0]       clock_ms;

  function automatic void model_reset();
    for (int i = 0; i < 5; i++) ring[i] = '0;
    ring_pos = 0;
    enemy_flag = 1'b0;
    enemy_time = '0;
    left_conf = 1'b0;
    right_conf = 1'b0;
    left_cnt = '0;
    right_cnt = '0;
    mode = MODE_WAIT;
    mode_time = '0;
    edge_side = SIDE_BOTH;
    spin_ccw = 1'b0;
    drive_left = '0;
    drive_right = '0;
    drive_coast = 1'b1;
    reg_val[REG_ON]    = 1250;
    reg_val[REG_OFF]   = 1000;
    reg_val[REG_HOLD]  = 350;
    reg_val[REG_START] = 5000;
    reg_val[REG_BACK]  = 220;
    reg_val[REG_TURN]  = 260;
    reg_val[REG_SPIN]  = 480;
    reg_val[REG_PROBE] = 300;
  endfunction

  // two differing readings in a row flip the confirmed state
  function automatic void debounce(input logic raw, inout logic conf, inout logic [1:0] cnt);
    if (raw == conf) begin
      cnt = '0;
    end else begin
      cnt = cnt + 2'd1;
      if (cnt >= 2) begin
        conf = raw;
        cnt = '0;
      end
    end
  endfunction

  function automatic void set_drive(input logic signed [8:0] l, input logic signed [8:0] r,
                                    input logic c);
    drive_left = l;
    drive_right = r;
    drive_coast = c;
  endfunction

  function automatic result_t predict_tick(input logic [11:0] sample, input logic lvl_l,
                                           input logic lvl_r, input logic [31:0] now);
    logic [11:0]       sorted [5];
    logic [11:0]       tmp;
    logic [11:0]       med;
    logic [31:0]       elapsed;
    logic [31:0]       cycle;
    logic [31:0]       phase;
    logic [31:0]       dur;
    logic signed [8:0] spin;
    result_t           r;
    debounce(lvl_l == WHITE_LEVEL, left_conf, left_cnt);
    debounce(lvl_r == WHITE_LEVEL, right_conf, right_cnt);
    // median of the sample ring
    ring[ring_pos] = sample;
    ring_pos = (ring_pos + 1) % 5;
    for (int i = 0; i < 5; i++) sorted[i] = ring[i];
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4 - i; j++)
        if (sorted[j] > sorted[j + 1]) begin
          tmp = sorted[j];
          sorted[j] = sorted[j + 1];
          sorted[j + 1] = tmp;
        end
    med = sorted[2];
    // enemy hysteresis and hold
    if (!enemy_flag) begin
      if (med >= reg_val[REG_ON]) begin
        enemy_flag = 1'b1;
        enemy_time = now;
      end
    end else if (med >= reg_val[REG_OFF]) begin
      enemy_time = now;
    end else if (now - enemy_time > reg_val[REG_HOLD]) begin
      enemy_flag = 1'b0;
    end
    // line has priority
    if ((mode == MODE_SEARCH || mode == MODE_ATTACK) && (left_conf || right_conf)) begin
      edge_side = (left_conf && right_conf) ? SIDE_BOTH : (left_conf ? SIDE_LEFT : SIDE_RIGHT);
      mode = MODE_BACK;
      mode_time = now;
    end
    elapsed = now - mode_time;
    spin = spin_ccw ? -SPEED_SEARCH : SPEED_SEARCH;
    case (mode)
      MODE_WAIT: begin
        set_drive('0, '0, 1'b1);
        if (elapsed >= reg_val[REG_START]) begin
          mode = MODE_SEARCH;
          mode_time = now;
        end
      end
      MODE_SEARCH: begin
        if (enemy_flag) begin
          mode = MODE_ATTACK;
          mode_time = now;
        end else begin
          cycle = reg_val[REG_SPIN] + reg_val[REG_PROBE];
          phase = (cycle == 0) ? 32'd0 : elapsed % cycle;
          if (phase < reg_val[REG_SPIN]) set_drive(spin, -spin, 1'b0);
          else set_drive(SPEED_SEARCH, SPEED_SEARCH, 1'b0);
        end
      end
      MODE_ATTACK: begin
        if (!enemy_flag) begin
          mode = MODE_SEARCH;
          mode_time = now;
        end else begin
          set_drive(SPEED_ATTACK, SPEED_ATTACK, 1'b0);
        end
      end
      MODE_BACK: begin
        set_drive(-SPEED_BACK, -SPEED_BACK, 1'b0);
        if (elapsed >= reg_val[REG_BACK]) begin
          mode = MODE_TURN;
          mode_time = now;
        end
      end
      default: begin
        if (edge_side == SIDE_RIGHT) set_drive(-SPEED_TURN, SPEED_TURN, 1'b0);
        else set_drive(SPEED_TURN, -SPEED_TURN, 1'b0);
        dur = (edge_side == SIDE_BOTH) ? reg_val[REG_TURN] * 2 : reg_val[REG_TURN];
        if (elapsed >= dur) begin
          spin_ccw = ~spin_ccw;
          mode = MODE_SEARCH;
          mode_time = now;
        end
      end
    endcase
    r.left_speed = drive_left;
    r.right_speed = drive_right;
    r.coast = drive_coast;
    r.mode_code = mode;
    r.enemy_seen = enemy_flag;
    r.median_sample = med;
    r.left_on_line = left_conf;
    r.right_on_line = right_conf;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one tick request and predict its result on acceptance
  task automatic send_tick(input logic [11:0] sample, input logic lvl_l, input logic lvl_r,
                           input logic [31:0] now, input bit allow_gap);
    int gap;
    @(negedge clk);
    push <= 1'b1;
    in_distance_sample <= sample;
    in_left_line_level <= lvl_l;
    in_right_line_level <= lvl_r;
    in_now_ms <= now;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_ticks.push_back(predict_tick(sample, lvl_l, lvl_r, now));
    ticks_sent++;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (expected_ticks.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_val[idx] = (idx == REG_ON || idx == REG_OFF) ? {20'd0, data[11:0]} : {16'd0, data};
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(input logic [15:0] on_lvl, input logic [15:0] off_lvl,
                             input logic [15:0] hold, input logic [15:0] start,
                             input logic [15:0] back, input logic [15:0] turn,
                             input logic [15:0] spin, input logic [15:0] probe);
    wait_drained();
    write_reg(REG_ON, on_lvl);
    write_reg(REG_OFF, off_lvl);
    write_reg(REG_HOLD, hold);
    write_reg(REG_START, start);
    write_reg(REG_BACK, back);
    write_reg(REG_TURN, turn);
    write_reg(REG_SPIN, spin);
    write_reg(REG_PROBE, probe);
  endtask

  // reset values: coasting in wait until the start time runs out
  task automatic test_reset_wait();
    send_tick(12'd0, 1'b1, 1'b1, 32'd0, 1'b1);
    send_tick(12'd4095, 1'b1, 1'b1, 32'd4999, 1'b1);
    send_tick(12'd4095, 1'b1, 1'b1, 32'd5000, 1'b1);
    send_tick(12'd4095, 1'b1, 1'b1, 32'd5010, 1'b1);
    send_tick(12'd0, 1'b0, 1'b0, 32'd5020, 1'b1);
    send_tick(12'd0, 1'b0, 1'b0, 32'd5030, 1'b1);
  endtask

  // edges, zero back-off, both-side turn, held drive on mode change, zero cycle, wrap
  task automatic test_directed_cases();
    logic [31:0] t;
    load_config(16'hF7D0, 16'd1000, 16'd3, 16'd0, 16'd0, 16'd4, 16'd5, 16'd5);
    t = 32'hFFFF_FFF0;
    send_tick(12'd0, 1'b1, 1'b1, t, 1'b1);
    for (int i = 0; i < 4; i++) send_tick(12'd4095, 1'b1, 1'b1, t + 1 + i, 1'b1);
    for (int i = 0; i < 4; i++) send_tick(12'd0, 1'b1, 1'b1, t + 10 + i, 1'b1);
    send_tick(12'd0, 1'b0, 1'b1, t + 20, 1'b1);
    send_tick(12'd0, 1'b0, 1'b1, t + 21, 1'b1);
    send_tick(12'd0, 1'b1, 1'b1, t + 30, 1'b1);
    send_tick(12'd0, 1'b1, 1'b1, t + 31, 1'b1);
    send_tick(12'd0, 1'b0, 1'b0, t + 40, 1'b1);
    send_tick(12'd0, 1'b0, 1'b0, t + 41, 1'b1);
    send_tick(12'd0, 1'b1, 1'b1, t + 45, 1'b1);
    send_tick(12'd0, 1'b1, 1'b1, t + 46, 1'b1);
    send_tick(12'd0, 1'b1, 1'b1, t + 60, 1'b1);
    load_config(16'd4095, 16'd4095, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 4; i++) send_tick(12'd2000, 1'b1, 1'b1, 32'd100 + i * 7, 1'b1);
  endtask

  // random ticks with bursts of enemy signal and line runs
  task automatic test_random_run(input int count, input int max_step);
    bit          enemy_near;
    int          line_run;
    int          line_pick;
    logic [11:0] sample;
    logic        lvl_l, lvl_r;
    int          roll;
    clock_ms = $urandom();
    enemy_near = 1'b0;
    line_run = 0;
    line_pick = 0;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) enemy_near = ~enemy_near;
      if (roll < 10) sample = 12'($urandom());
      else if (enemy_near) sample = 12'($urandom_range(1500, 4095));
      else sample = 12'($urandom_range(0, 1400));
      if (line_run == 0 && $urandom_range(0, 24) == 0) begin
        line_run = $urandom_range(1, 4);
        line_pick = $urandom_range(0, 2);
      end
      lvl_l = 1'b1;
      lvl_r = 1'b1;
      if (line_run > 0) begin
        lvl_l = (line_pick == 1) ? 1'b1 : 1'b0;
        lvl_r = (line_pick == 0) ? 1'b1 : 1'b0;
        line_run--;
      end else if (roll >= 95) begin
        lvl_l = 1'($urandom_range(0, 1));
        lvl_r = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, max_step);
      send_tick(sample, lvl_l, lvl_r, clock_ms, 1'b1);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && pop && !empty) begin
      if (expected_ticks.size() == 0) begin
        $error("result with no tick outstanding");
        errors++;
      end else begin
        exp_r = expected_ticks.pop_front();
        ticks_done++;
        if (out_left_speed !== exp_r.left_speed) begin
          $error("left_speed exp %0d got %0d", exp_r.left_speed, out_left_speed);
          errors++;
        end
        if (out_right_speed !== exp_r.right_speed) begin
          $error("right_speed exp %0d got %0d", exp_r.right_speed, out_right_speed);
          errors++;
        end
        if (out_coast !== exp_r.coast) begin
          $error("coast exp %0b got %0b", exp_r.coast, out_coast);
          errors++;
        end
        if (out_mode_code !== exp_r.mode_code) begin
          $error("mode_code exp %0d got %0d", exp_r.mode_code, out_mode_code);
          errors++;
        end
        if (out_enemy_seen !== exp_r.enemy_seen) begin
          $error("enemy_seen exp %0b got %0b", exp_r.enemy_seen, out_enemy_seen);
          errors++;
        end
        if (out_median_sample !== exp_r.median_sample) begin
          $error("median_sample exp %0d got %0d", exp_r.median_sample, out_median_sample);
          errors++;
        end
        if (out_left_on_line !== exp_r.left_on_line) begin
          $error("left_on_line exp %0b got %0b", exp_r.left_on_line, out_left_on_line);
          errors++;
        end
        if (out_right_on_line !== exp_r.right_on_line) begin
          $error("right_on_line exp %0b got %0b", exp_r.right_on_line, out_right_on_line);
          errors++;
        end
      end
    end
  end

  // receiver stalls, with stretches of none
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    if (!stall_mode) pop <= 1'b1;
    else if ($urandom_range(0, 49) == 0) pop <= 1'b0;
    else pop <= ($urandom_range(0, 2) == 0);
  end

  // watchdog on cycles without any push, pop or register write accepted
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_distance_sample = '0;
    in_left_line_level = 1'b1;
    in_right_line_level = 1'b1;
    in_now_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stall_mode = 1'b0;
    errors = 0;
    ticks_sent = 0;
    ticks_done = 0;
    cfg_writes = 0;
    idle_cycles = 0;
    model_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_wait();
    test_directed_cases();
    load_config(16'd1800, 16'd900, 16'd20, 16'd30, 16'd15, 16'd12, 16'd25, 16'd18);
    test_random_run(190, 12);
    load_config(16'd0, 16'd4095, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
                16'd65535, 16'd65535);
    test_random_run(90, 6000);
    load_config(16'd4095, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    test_random_run(90, 3);
    load_config(16'($urandom()), 16'($urandom()), 16'($urandom_range(0, 60)),
                16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)),
                16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)),
                16'($urandom_range(0, 60)));
    test_random_run(190, 15);
    load_config(16'd1250, 16'd1000, 16'd350, 16'd5000, 16'd220, 16'd260, 16'd480, 16'd300);
    test_random_run(190, 40);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d ticks and %0d register writes over several register sets,",
             ticks_sent, cfg_writes);
    $display("including edges on each side, zero timers, extreme levels and time wrap");
    if (errors == 0 && expected_ticks.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/src_pkg.sv
rtl/core/src_front.sv
rtl/core/src_back.sv
rtl/core/sumo_robot_combat_controller.sv
test/tb_sumo_robot_combat_controller.sv
